// ===== rtl/bbct_pkg.sv =====
// Shared types, codes and defaults for the block buffer cache tag engine.
package bbct_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int REF_BITS_DEF = 8;
  localparam int CMD_W        = 3;
  localparam int BLOCK_W      = 31;
  localparam int SLOT_W       = 4;
  localparam int STATUS_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET   = 3'd0,
    CMD_DIRTY = 3'd1,
    CMD_REL   = 3'd2,
    CMD_SYNC  = 3'd3,
    CMD_INVAL = 3'd4
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_MISS  = 3'd1,
    ST_BUSY  = 3'd2,
    ST_NOREF = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_GET_SCAN,
    S_GET_END,
    S_SYNC_SCAN,
    S_SYNC_END
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_run;
    logic get_finish;
    logic sync_finish;
    logic slot_op;
  } bbct_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
  } bbct_stat_t;

endpackage

// ===== rtl/bbct_ctrl.sv =====
// Command sequencer of the cache tag engine.
module bbct_ctrl import bbct_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CMD_W-1:0]   cmd,
  input  bbct_stat_t         stat,
  output logic               busy,
  output bbct_ctl_t          ctl
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load = 1'b1;
          case (cmd)
            CMD_GET:  state_next = S_GET_SCAN;
            CMD_SYNC: state_next = S_SYNC_SCAN;
            default:  state_next = S_OP;
          endcase
        end
      end
      S_OP: begin
        ctl.slot_op = 1'b1;
        state_next  = S_IDLE;
      end
      S_GET_SCAN: begin
        ctl.scan_run = 1'b1;
        if (stat.scan_last) begin
          state_next = S_GET_END;
        end
      end
      S_GET_END: begin
        ctl.get_finish = 1'b1;
        state_next     = S_IDLE;
      end
      S_SYNC_SCAN: begin
        ctl.scan_run = 1'b1;
        if (stat.scan_last) begin
          state_next = S_SYNC_END;
        end
      end
      S_SYNC_END: begin
        ctl.sync_finish = 1'b1;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bbct_dp.sv =====
// Slot state, tag memory, scan pipeline and result registers of the cache tag engine.
module bbct_dp import bbct_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int REF_BITS = REF_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [BLOCK_W-1:0]  block_no,
  input  logic [SLOT_W-1:0]   slot,
  input  bbct_ctl_t           ctl,
  output bbct_stat_t          stat,
  output logic                result_strobe,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   result_slot,
  output logic                writeback_valid,
  output logic [BLOCK_W-1:0]  writeback_block,
  output logic                last
);

  localparam int SW = $clog2(SLOTS);
  localparam int KW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0]       LAST_IDX = SW'(SLOTS - 1);
  localparam logic [KW-1:0]       CNT_END  = KW'(SLOTS);
  localparam logic [REF_BITS-1:0] REF_MAX  = '1;
  localparam logic [REF_BITS-1:0] REF_ONE  = REF_BITS'(1);

  // Per-slot state
  logic [BLOCK_W-1:0]  tag_mem [SLOTS];
  logic                valid   [SLOTS];
  logic [REF_BITS-1:0] refs    [SLOTS];
  logic                dirty   [SLOTS];
  logic [SW-1:0]       sp;
  logic [KW-1:0]       occ;

  // Latched command beat
  logic [CMD_W-1:0]    cmd_r;
  logic [BLOCK_W-1:0]  tag_r;
  logic [SLOT_W-1:0]   slot_r;

  // Scan pipeline: read stage and compare stage
  logic [SW-1:0]       ptr;
  logic [KW-1:0]       cnt;
  logic                rd_valid;
  logic [SW-1:0]       rd_idx;
  logic [BLOCK_W-1:0]  rd_tag;
  logic                rd_v;
  logic                rd_zero;
  logic                rd_d;

  // Scan findings
  logic                hit_f;
  logic [SW-1:0]       hit_idx;
  logic                free_f;
  logic [SW-1:0]       free_idx;
  logic                vic_f;
  logic [SW-1:0]       vic_idx;
  logic                vic_d;
  logic [BLOCK_W-1:0]  vic_tag;
  logic                pend_f;
  logic [SW-1:0]       pend_idx;
  logic [BLOCK_W-1:0]  pend_tag;

  // Slot field checked against the slot count
  logic [SW+SLOT_W-1:0] s_ext;
  logic                 s_in;
  logic [SW-1:0]        s_idx;
  logic [SW-1:0]        ptr_next;
  logic [SW-1:0]        vic_next;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [SW-1:0] i);
    logic [SW+SLOT_W-1:0] x;
    x = {{SLOT_W{1'b0}}, i};
    return x[SLOT_W-1:0];
  endfunction

  assign s_ext    = {{SW{1'b0}}, slot_r};
  assign s_in     = s_ext < (SW+SLOT_W)'(SLOTS);
  assign s_idx    = s_ext[SW-1:0];
  assign ptr_next = (ptr == LAST_IDX) ? '0 : ptr + SW'(1);
  assign vic_next = (vic_idx == LAST_IDX) ? '0 : vic_idx + SW'(1);

  assign stat.scan_last = ctl.scan_run && (cnt == CNT_END);

  // Tag memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.get_finish && !hit_f) begin
      if (occ != CNT_END) begin
        tag_mem[free_idx] <= tag_r;
      end else if (vic_f) begin
        tag_mem[vic_idx] <= tag_r;
      end
    end
    if (ctl.scan_run && cnt != CNT_END) begin
      rd_tag <= tag_mem[ptr];
    end
  end

  // Control state, slot flags and result beats
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        valid[i] <= 1'b0;
        refs[i]  <= '0;
        dirty[i] <= 1'b0;
      end
      sp            <= '0;
      occ           <= '0;
      rd_valid      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;

      // Take the command beat
      if (ctl.load) begin
        cmd_r    <= cmd;
        tag_r    <= block_no;
        slot_r   <= slot;
        ptr      <= (cmd == CMD_GET) ? sp : '0;
        cnt      <= '0;
        rd_valid <= 1'b0;
        hit_f    <= 1'b0;
        free_f   <= 1'b0;
        vic_f    <= 1'b0;
        pend_f   <= 1'b0;
      end

      // Scan: read one slot a cycle, compare the previous one
      if (ctl.scan_run) begin
        if (cnt != CNT_END) begin
          rd_idx   <= ptr;
          rd_v     <= valid[ptr];
          rd_zero  <= (refs[ptr] == '0);
          rd_d     <= dirty[ptr];
          rd_valid <= 1'b1;
          ptr      <= ptr_next;
          cnt      <= cnt + KW'(1);
        end else begin
          rd_valid <= 1'b0;
        end
        if (rd_valid) begin
          if (cmd_r == CMD_GET) begin
            if (rd_v && rd_tag == tag_r) begin
              hit_f   <= 1'b1;
              hit_idx <= rd_idx;
            end
            // lowest free slot, whatever the scan order
            if (!rd_v && (!free_f || rd_idx < free_idx)) begin
              free_f   <= 1'b1;
              free_idx <= rd_idx;
            end
            // first unreferenced slot from the rotating pointer
            if (rd_v && rd_zero && !vic_f) begin
              vic_f   <= 1'b1;
              vic_idx <= rd_idx;
              vic_d   <= rd_d;
              vic_tag <= rd_tag;
            end
          end else if (rd_v && rd_d) begin
            // sync: hold one beat back so the final one can carry last
            dirty[rd_idx] <= 1'b0;
            if (pend_f) begin
              result_strobe   <= 1'b1;
              status          <= ST_OK;
              result_slot     <= to_slot(pend_idx);
              writeback_valid <= 1'b1;
              writeback_block <= pend_tag;
              last            <= 1'b0;
            end
            pend_f   <= 1'b1;
            pend_idx <= rd_idx;
            pend_tag <= rd_tag;
          end
        end
      end

      // Get outcome
      if (ctl.get_finish) begin
        result_strobe   <= 1'b1;
        last            <= 1'b1;
        writeback_valid <= 1'b0;
        writeback_block <= '0;
        if (hit_f) begin
          if (refs[hit_idx] != REF_MAX) begin
            refs[hit_idx] <= refs[hit_idx] + REF_ONE;
          end
          status      <= ST_OK;
          result_slot <= to_slot(hit_idx);
        end else if (occ != CNT_END) begin
          valid[free_idx] <= 1'b1;
          refs[free_idx]  <= REF_ONE;
          dirty[free_idx] <= 1'b0;
          occ             <= occ + KW'(1);
          status          <= ST_MISS;
          result_slot     <= to_slot(free_idx);
        end else if (vic_f) begin
          refs[vic_idx]   <= REF_ONE;
          dirty[vic_idx]  <= 1'b0;
          sp              <= vic_next;
          status          <= ST_MISS;
          result_slot     <= to_slot(vic_idx);
          writeback_valid <= vic_d;
          writeback_block <= vic_d ? vic_tag : '0;
        end else begin
          status      <= ST_BUSY;
          result_slot <= '0;
        end
      end

      // Sync closing beat
      if (ctl.sync_finish) begin
        result_strobe <= 1'b1;
        status        <= ST_OK;
        last          <= 1'b1;
        if (pend_f) begin
          result_slot     <= to_slot(pend_idx);
          writeback_valid <= 1'b1;
          writeback_block <= pend_tag;
        end else begin
          result_slot     <= '0;
          writeback_valid <= 1'b0;
          writeback_block <= '0;
        end
      end

      // Single-slot commands and unknown codes
      if (ctl.slot_op) begin
        result_strobe   <= 1'b1;
        last            <= 1'b1;
        writeback_valid <= 1'b0;
        writeback_block <= '0;
        result_slot     <= slot_r;
        status          <= ST_OK;
        if (cmd_r == CMD_DIRTY || cmd_r == CMD_REL || cmd_r == CMD_INVAL) begin
          if (!s_in || !valid[s_idx]) begin
            status <= ST_EMPTY;
          end else if (cmd_r == CMD_INVAL) begin
            valid[s_idx] <= 1'b0;
            refs[s_idx]  <= '0;
            dirty[s_idx] <= 1'b0;
            if (occ != '0) begin
              occ <= occ - KW'(1);
            end
          end else if (refs[s_idx] == '0) begin
            status <= ST_NOREF;
          end else if (cmd_r == CMD_DIRTY) begin
            dirty[s_idx] <= 1'b1;
          end else begin
            refs[s_idx] <= refs[s_idx] - REF_ONE;
          end
        end else begin
          result_slot <= '0;
        end
      end
    end
  end

endmodule

// ===== rtl/block_buffer_cache_tags.sv =====
// Top level of the block buffer cache tag engine.
//
// Tag and replacement engine of a fully associative disk block cache with
// SLOTS slots. A command beat is taken when start is high and busy is low;
// busy then stays high until the command's final result. Each result beat
// is shown for exactly one cycle with result_strobe high and cannot be
// held off, so the receiver must take it then. Get and sync walk the tag
// memory through its single read port one slot per cycle; a sync gives
// one beat per dirty slot in ascending order, the last one flagged by last,
// or a single beat with writeback_valid low when no slot is dirty. Mark
// dirty, release, invalidate and unknown codes give their result after the
// S_OP state. A new command may be started in the cycle of a final beat.
module block_buffer_cache_tags import bbct_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int REF_BITS = REF_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [BLOCK_W-1:0]  block_no,
  input  logic [SLOT_W-1:0]   slot,
  output logic                result_strobe,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   result_slot,
  output logic                writeback_valid,
  output logic [BLOCK_W-1:0]  writeback_block,
  output logic                last
);

  bbct_ctl_t  ctl;
  bbct_stat_t stat;

  // Sequencer
  bbct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  // Slot state and result path
  bbct_dp #(
    .SLOTS    (SLOTS),
    .REF_BITS (REF_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .block_no        (block_no),
    .slot            (slot),
    .ctl             (ctl),
    .stat            (stat),
    .result_strobe   (result_strobe),
    .status          (status),
    .result_slot     (result_slot),
    .writeback_valid (writeback_valid),
    .writeback_block (writeback_block),
    .last            (last)
  );

endmodule
